>>> design/mlrr_pkg.sv
package mlrr_pkg;

  localparam int PORTS      = 8;
  localparam int RING_DEPTH = 8192;

  // Field widths fixed by the interface
  localparam int PORT_W     = 3;
  localparam int BYTE_W     = 8;
  localparam int OUT_CNT_W  = 14;

  localparam int PSEL_W     = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int ADDR_W     = PSEL_W + IDX_W;
  localparam int MEM_DEPTH  = PORTS * RING_DEPTH;

  localparam logic [31:0]      PORTS_U32 = 32'(PORTS);
  localparam logic [IDX_W:0]   IDX_LAST  = (IDX_W + 1)'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(RING_DEPTH);

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  function automatic logic is_eol(input logic [BYTE_W-1:0] b);
    return (b == CHAR_CR) || (b == CHAR_LF);
  endfunction

  // Ring index advance with wrap at RING_DEPTH
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] ext;
    ext = {1'b0, idx};
    return (ext == IDX_LAST) ? '0 : IDX_W'(ext + 1'b1);
  endfunction

endpackage

>>> design/mlrr_ring_ram.sv
module mlrr_ring_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 8,
  parameter int DEPTH  = 65536
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/multiport_line_receive_ring.sv
// Per-port receive rings with byte and line counts, one ring per serial port.
// Input channel (in_valid/in_ready): in_command push (store in_data_byte in
// the ring of in_port) or pop (take the oldest byte of that ring).
// Result channel (out_valid/out_ready): one result item per input item, with
// the popped byte, line-end flag, empty/dropped flags and the port's counts
// after the operation.
// After an item is accepted, the block runs the execute state and then offers
// the result item; a pop that reads the ring runs a read state in between for
// the ring RAM read.
// The block takes one item at a time and takes no new item until the result of
// the last is taken. Each item runs the control sequence (idle, execute, hold
// result), and a pop that reads the ring adds a RAM read state to it.
// Reset (rst_n low, synchronous) clears every port's indices and counts; ring
// contents are not cleared, since a pop only reads bytes already pushed.
// No clearing pass: the block accepts items the cycle after reset.
// A stalled receiver (out_ready low) holds the result item steady and keeps
// in_ready low until it is taken.
module multiport_line_receive_ring
  import mlrr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  input  logic [PORT_W-1:0]    in_port,
  input  logic [BYTE_W-1:0]    in_data_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_read_byte,
  output logic                 out_is_line_end,
  output logic                 out_was_empty,
  output logic                 out_was_dropped,
  output logic [OUT_CNT_W-1:0] out_bytes_held,
  output logic [OUT_CNT_W-1:0] out_lines_held
);

  state_t state_r, state_nxt;

  // Latched item
  cmd_t              cmd_r;
  logic [PORT_W-1:0] port_r;
  logic [BYTE_W-1:0] data_r;

  // Per-port control state
  logic [IDX_W-1:0] wr_idx_r   [PORTS];
  logic [IDX_W-1:0] rd_idx_r   [PORTS];
  logic [CNT_W-1:0] byte_cnt_r [PORTS];
  logic [CNT_W-1:0] line_cnt_r [PORTS];

  // Result register
  logic [BYTE_W-1:0]    res_byte_r;
  logic                 res_eol_r;
  logic                 res_empty_r;
  logic                 res_drop_r;
  logic [OUT_CNT_W-1:0] res_bytes_r;
  logic [OUT_CNT_W-1:0] res_lines_r;

  logic [PSEL_W-1:0] psel;
  logic              port_ok;
  logic              ring_full;
  logic              ring_empty;
  logic              data_eol;
  logic              rd_eol;
  logic [CNT_W-1:0]  cur_bytes;
  logic [CNT_W-1:0]  cur_lines;
  logic [CNT_W-1:0]  push_lines;
  logic [CNT_W-1:0]  pop_lines;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  assign psel       = PSEL_W'(port_r);
  assign port_ok    = ({{(32 - PORT_W){1'b0}}, port_r} < PORTS_U32);
  assign cur_bytes  = byte_cnt_r[psel];
  assign cur_lines  = line_cnt_r[psel];
  assign ring_full  = (cur_bytes >= CNT_FULL);
  assign ring_empty = (cur_bytes == '0);
  assign data_eol   = is_eol(data_r);
  assign rd_eol     = is_eol(ram_rdata);
  assign push_lines = data_eol ? CNT_W'(cur_lines + 1'b1) : cur_lines;
  assign pop_lines  = (rd_eol && (cur_lines != '0)) ? CNT_W'(cur_lines - 1'b1) : cur_lines;

  assign ram_waddr  = {psel, wr_idx_r[psel]};
  assign ram_raddr  = {psel, rd_idx_r[psel]};

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        if (port_ok) begin
          if (cmd_r == CMD_PUSH) begin
            ram_we = !ring_full;
          end else if (!ring_empty) begin
            ram_re    = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < PORTS; i++) begin
        wr_idx_r[i]   <= '0;
        rd_idx_r[i]   <= '0;
        byte_cnt_r[i] <= '0;
        line_cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        wr_idx_r[psel]   <= idx_next(wr_idx_r[psel]);
        byte_cnt_r[psel] <= CNT_W'(cur_bytes + 1'b1);
        line_cnt_r[psel] <= push_lines;
      end
      if (ram_re) begin
        rd_idx_r[psel]   <= idx_next(rd_idx_r[psel]);
        byte_cnt_r[psel] <= CNT_W'(cur_bytes - 1'b1);
      end
      // line count settles once the popped byte is back from the RAM
      if (state_r == S_READ) begin
        line_cnt_r[psel] <= pop_lines;
      end
    end
  end

  // Item latch and result register
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r  <= cmd_t'(in_command);
      port_r <= in_port;
      data_r <= in_data_byte;
    end
    if (state_r == S_EXEC) begin
      res_byte_r  <= '0;
      res_eol_r   <= 1'b0;
      res_empty_r <= 1'b0;
      res_drop_r  <= 1'b0;
      res_bytes_r <= '0;
      res_lines_r <= '0;
      if (port_ok) begin
        res_bytes_r <= OUT_CNT_W'(cur_bytes);
        res_lines_r <= OUT_CNT_W'(cur_lines);
        if (cmd_r == CMD_PUSH) begin
          if (ring_full) begin
            res_drop_r <= 1'b1;
          end else begin
            res_eol_r   <= data_eol;
            res_bytes_r <= OUT_CNT_W'(cur_bytes + 1'b1);
            res_lines_r <= OUT_CNT_W'(push_lines);
          end
        end else if (ring_empty) begin
          res_empty_r <= 1'b1;
        end else begin
          res_bytes_r <= OUT_CNT_W'(cur_bytes - 1'b1);
        end
      end
    end
    if (state_r == S_READ) begin
      res_byte_r  <= ram_rdata;
      res_eol_r   <= rd_eol;
      res_lines_r <= OUT_CNT_W'(pop_lines);
    end
  end

  mlrr_ring_ram #(
    .ADDR_W(ADDR_W),
    .DATA_W(BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ring_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(data_r),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_RESP);
  assign out_read_byte   = res_byte_r;
  assign out_is_line_end = res_eol_r;
  assign out_was_empty   = res_empty_r;
  assign out_was_dropped = res_drop_r;
  assign out_bytes_held  = res_bytes_r;
  assign out_lines_held  = res_lines_r;

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state register not one-hot");

  a_ram_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re)) else $error("ring RAM written and read together");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && port_ok) |-> (cur_bytes <= CNT_FULL && cur_lines <= cur_bytes))
    else $error("port counts out of range");

  a_read_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (state_r == S_READ)) else $error("RAM read not followed by capture");

  a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_dropped) |-> (!out_is_line_end && out_read_byte == '0
      && !out_was_empty)) else $error("dropped item carries data");
`endif

endmodule
